// ===== sv/ctpr_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ctpr_pkg
// Types and fixed constants shared by the coil temperature regulator files.
// ----------------------------------------------------------------------------
package ctpr_pkg;

    // Fixed field widths
    localparam int RES_W   = 15;   // coil resistance, milliohms
    localparam int SP_W    = 9;    // temperature setpoint, whole degrees
    localparam int GAIN_W  = 10;   // PID gains
    localparam int DRIVE_W = 16;   // drive value
    localparam int TEMP_W  = 19;   // Q.F coil temperature
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 15;

    // Datapath widths of the iterative unit and the multiplier
    localparam int DEN_W     = 30; // base * tcr < 2^30
    localparam int RAD_W     = 32; // 80000 * R < 2^32
    localparam int ROOT_W    = 16; // floor(sqrt(80000 * R)) < 2^16
    localparam int MAGPROD_W = 35; // |R - base| * 1e6 < 2^35
    localparam int OPA_W     = 20; // unsigned multiplier operand

    // Scale constants
    localparam logic [OPA_W-1:0] RAD_SCALE = OPA_W'(80000);
    localparam logic [OPA_W-1:0] PPM_SCALE = OPA_W'(1000000);
    localparam int REF_TEMP_C = 20;
    localparam int TEMP_MAX   = 262143;
    localparam int TEMP_MIN   = -262144;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_SETPOINT = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_TCR      = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_BASE     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_GAIN_P   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_GAIN_I   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_GAIN_D   = 3'd5;

    // Register reset values
    localparam logic [SP_W-1:0]   RST_SETPOINT = 9'd200;
    localparam logic [RES_W-1:0]  RST_TCR      = 15'd4300;
    localparam logic [RES_W-1:0]  RST_BASE     = 15'd300;
    localparam logic [GAIN_W-1:0] RST_GAIN_P   = 10'd64;
    localparam logic [GAIN_W-1:0] RST_GAIN_I   = 10'd12;
    localparam logic [GAIN_W-1:0] RST_GAIN_D   = 10'd16;

    // Sequencer states
    typedef enum logic [3:0] {
        S_IDLE,
        S_MSQ,
        S_MDEN,
        S_MNUM,
        S_LOAD,
        S_DIV,
        S_SQRT,
        S_TEMP,
        S_MI,
        S_INT,
        S_MP,
        S_MD,
        S_SUM,
        S_FIN
    } t_state;

    // Commands to the shared divide / square-root unit
    typedef struct packed {
        logic div_load;
        logic div_step;
        logic sqrt_load;
        logic sqrt_step;
    } t_iter_ctrl;

endpackage
`default_nettype wire

// ===== sv/ctpr_iter_unit.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ctpr_iter_unit
// Restoring divider and digit-by-digit square root on one shared subtractor.
// ----------------------------------------------------------------------------
module ctpr_iter_unit import ctpr_pkg::*; #(
    parameter int NUM_W = 43
) (
    input  wire logic              i_clk,
    input  wire t_iter_ctrl        i_ctrl,
    input  wire logic [NUM_W-1:0]  i_dividend,
    input  wire logic [DEN_W-1:0]  i_divisor,
    input  wire logic [RAD_W-1:0]  i_radicand,
    output logic      [NUM_W-1:0]  o_quotient,
    output logic      [ROOT_W-1:0] o_root,
    output logic                   o_sqrt_last
);

    localparam int SUB_W = RAD_W + 1;

    logic [NUM_W-1:0] r_dvd;
    logic [DEN_W-1:0] r_rem;
    logic [RAD_W-1:0] r_v;
    logic [RAD_W-1:0] r_root;
    logic [RAD_W-1:0] r_bit;

    logic [DEN_W:0]   rem_shift;
    logic [SUB_W-1:0] sub_a;
    logic [SUB_W-1:0] sub_b;
    logic [SUB_W:0]   diff;
    logic             ge;

    assign rem_shift = {r_rem, r_dvd[NUM_W-1]};

    // Shared subtract and compare
    always_comb begin
        if (i_ctrl.div_step) begin
            sub_a = SUB_W'(rem_shift);
            sub_b = SUB_W'(i_divisor);
        end else begin
            sub_a = SUB_W'(r_v);
            sub_b = SUB_W'(r_root) + SUB_W'(r_bit);
        end
        diff = {1'b0, sub_a} - {1'b0, sub_b};
        ge   = ~diff[SUB_W];
    end

    always_ff @(posedge i_clk) begin
        if (i_ctrl.div_load) begin
            r_dvd <= i_dividend;
            r_rem <= '0;
        end else if (i_ctrl.div_step) begin
            r_rem <= ge ? diff[DEN_W-1:0] : rem_shift[DEN_W-1:0];
            r_dvd <= {r_dvd[NUM_W-2:0], ge};
        end

        if (i_ctrl.sqrt_load) begin
            r_v    <= i_radicand;
            r_root <= '0;
            r_bit  <= RAD_W'(1) << (RAD_W - 2);
        end else if (i_ctrl.sqrt_step) begin
            if (ge) begin
                r_v    <= diff[RAD_W-1:0];
                r_root <= (r_root >> 1) + r_bit;
            end else begin
                r_root <= r_root >> 1;
            end
            r_bit <= r_bit >> 2;
        end
    end

    assign o_quotient  = r_dvd;
    assign o_root      = r_root[ROOT_W-1:0];
    assign o_sqrt_last = r_bit[0];

endmodule
`default_nettype wire

// ===== sv/coil_temperature_pid_regulator.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// coil_temperature_pid_regulator
// Resistance-to-temperature conversion and PID drive step for a heater coil.
// ----------------------------------------------------------------------------
// The bit-serial divide (one quotient bit per cycle) and the 16-step square
// root share one subtractor. A new beat is taken only in the idle state, once
// the last result has left the final state; i_ready low only stalls a
// finished result in its final state.
// Reset (synchronous, i_rst_n low): registers to defaults, history cleared, no beat taken.
// ----------------------------------------------------------------------------
module coil_temperature_pid_regulator import ctpr_pkg::*; #(
    parameter int TEMP_FRAC_BITS = 8
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    // configuration write port
    input  wire logic                  i_cfg_wr_en,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_data,
    // sample input
    input  wire logic                  i_valid,
    output logic                       o_ready,
    input  wire logic [RES_W-1:0]      i_coil_resistance,
    // result output
    output logic                       o_valid,
    input  wire logic                  i_ready,
    output logic [DRIVE_W-1:0]         o_drive_voltage,
    output logic signed [TEMP_W-1:0]   o_coil_temperature
);

    // ------------------------------------------------------------------
    // Widths derived from the fraction bit count
    // ------------------------------------------------------------------
    // dividend: |R - base| * 1e6 scaled by 2^F
    localparam int NUM_W = MAGPROD_W + TEMP_FRAC_BITS;
    localparam int CNT_W = $clog2(NUM_W);
    // quotient cap: anything at or above 2^CAP_W saturates either way
    localparam int CAP_W = ((TEMP_FRAC_BITS + 5) > 18 ? TEMP_FRAC_BITS + 5 : 18) + 1;
    localparam int TW    = CAP_W + 2;
    // error / delta width, product width, PID sum width, integral width
    localparam int E_W   = ((TEMP_FRAC_BITS + 9) > 18 ? TEMP_FRAC_BITS + 9 : 18) + 2;
    localparam int PW    = E_W + OPA_W + 1;
    localparam int SW    = PW + 2;
    localparam int IW    = ROOT_W + TEMP_FRAC_BITS;

    localparam logic signed [TW-1:0] REF_FX  = TW'(REF_TEMP_C * (2 ** TEMP_FRAC_BITS));
    localparam logic signed [TW-1:0] T_HI    = TW'(TEMP_MAX);
    localparam logic signed [TW-1:0] T_LO    = TW'(TEMP_MIN);
    localparam logic [IW-1:0]        ONE_FX  = IW'(1) << TEMP_FRAC_BITS;

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic [SP_W-1:0]   r_setpoint;
    logic [RES_W-1:0]  r_tcr;
    logic [RES_W-1:0]  r_base;
    logic [GAIN_W-1:0] r_gain_p;
    logic [GAIN_W-1:0] r_gain_i;
    logic [GAIN_W-1:0] r_gain_d;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_setpoint <= RST_SETPOINT;
            r_tcr      <= RST_TCR;
            r_base     <= RST_BASE;
            r_gain_p   <= RST_GAIN_P;
            r_gain_i   <= RST_GAIN_I;
            r_gain_d   <= RST_GAIN_D;
        end else if (i_cfg_wr_en) begin
            case (i_cfg_index)
                CFG_SETPOINT: r_setpoint <= i_cfg_data[SP_W-1:0];
                CFG_TCR:      r_tcr      <= i_cfg_data[RES_W-1:0];
                CFG_BASE:     r_base     <= i_cfg_data[RES_W-1:0];
                CFG_GAIN_P:   r_gain_p   <= i_cfg_data[GAIN_W-1:0];
                CFG_GAIN_I:   r_gain_i   <= i_cfg_data[GAIN_W-1:0];
                CFG_GAIN_D:   r_gain_d   <= i_cfg_data[GAIN_W-1:0];
                default: ;  // drop writes to unused indexes
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Sequencer and datapath registers
    // ------------------------------------------------------------------
    t_state r_state;
    t_state n_state;

    logic [CNT_W-1:0]        r_cnt;
    logic [RES_W-1:0]        r_coil_res;   // latched sample
    logic                    r_neg;        // R below base: negative offset
    logic [DEN_W-1:0]        r_den;        // base * tcr
    logic signed [PW-1:0]    r_prod;       // registered multiplier output
    logic [ROOT_W-1:0]       r_maxi;       // integer output limit
    logic signed [TEMP_W-1:0] r_temp;      // current temperature
    logic signed [TEMP_W-1:0] r_prev;      // previous temperature
    logic [IW-1:0]           r_integ;      // integral, in [0, max] or 1.0 when max is 0
    logic signed [SW-1:0]    r_sum;        // PID sum

    logic                    r_out_valid;
    logic [DRIVE_W-1:0]      r_out_drive;
    logic signed [TEMP_W-1:0] r_out_temp;

    // Shared multiplier operands
    logic [OPA_W-1:0]        mul_a;
    logic signed [E_W-1:0]   mul_b;
    logic signed [PW-1:0]    mul_prod;

    t_iter_ctrl              iter_ctrl;
    logic [NUM_W-1:0]        quotient;
    logic [ROOT_W-1:0]       root;
    logic                    sqrt_last;

    logic [RES_W-1:0]        base_eff;
    logic [RES_W-1:0]        tcr_eff;
    logic [RES_W-1:0]        mag;
    logic                    div_done;
    logic                    out_load;

    // Zero base or TCR acts as one
    assign base_eff = (r_base == '0) ? RES_W'(1) : r_base;
    assign tcr_eff  = (r_tcr == '0) ? RES_W'(1) : r_tcr;
    assign mag      = (r_coil_res < base_eff) ? (base_eff - r_coil_res)
                                              : (r_coil_res - base_eff);
    assign div_done = (r_cnt == CNT_W'(NUM_W - 1));
    assign out_load = (r_state == S_FIN) && (!r_out_valid || i_ready);

    ctpr_iter_unit #(
        .NUM_W (NUM_W)
    ) u_iter (
        .i_clk       (i_clk),
        .i_ctrl      (iter_ctrl),
        .i_dividend  ({r_prod[MAGPROD_W-1:0], {TEMP_FRAC_BITS{1'b0}}}),
        .i_divisor   (r_den),
        .i_radicand  (r_prod[RAD_W-1:0]),
        .o_quotient  (quotient),
        .o_root      (root),
        .o_sqrt_last (sqrt_last)
    );

    // ------------------------------------------------------------------
    // Temperature from the quotient: sign, offset by 20 degrees, saturate
    // ------------------------------------------------------------------
    logic                    q_big;
    logic [CAP_W:0]          q_cap;
    logic signed [TW-1:0]    t_mag;
    logic signed [TW-1:0]    t_wide;
    logic signed [TEMP_W-1:0] t_sat;

    always_comb begin
        q_big  = |quotient[NUM_W-1:CAP_W];
        q_cap  = q_big ? {1'b1, {CAP_W{1'b0}}} : {1'b0, quotient[CAP_W-1:0]};
        t_mag  = $signed(TW'(q_cap));
        t_wide = (r_neg ? -t_mag : t_mag) + REF_FX;
        if (t_wide > T_HI) begin
            t_sat = TEMP_W'(TEMP_MAX);
        end else if (t_wide < T_LO) begin
            t_sat = TEMP_W'(TEMP_MIN);
        end else begin
            t_sat = t_wide[TEMP_W-1:0];
        end
    end

    // ------------------------------------------------------------------
    // Error, derivative, integral clamp and drive clamp
    // ------------------------------------------------------------------
    logic signed [E_W-1:0]   err;
    logic signed [E_W-1:0]   delta;
    logic signed [SW-1:0]    max_s;
    logic signed [SW-1:0]    one_s;
    logic signed [SW-1:0]    integ_raw;
    logic [IW-1:0]           integ_clamped;
    logic [DRIVE_W-1:0]      drive;

    always_comb begin
        err   = $signed(E_W'({r_setpoint, {TEMP_FRAC_BITS{1'b0}}})) - E_W'(r_temp);
        delta = E_W'(r_temp) - E_W'(r_prev);
        max_s = $signed(SW'({r_maxi, {TEMP_FRAC_BITS{1'b0}}}));
        one_s = $signed(SW'(ONE_FX));

        integ_raw = SW'(r_prod) + $signed(SW'(r_integ));
        if (integ_raw > max_s) begin
            integ_clamped = {r_maxi, {TEMP_FRAC_BITS{1'b0}}};
        end else if (integ_raw < one_s) begin
            integ_clamped = ONE_FX;
        end else begin
            integ_clamped = integ_raw[IW-1:0];
        end

        if (r_sum > max_s) begin
            drive = r_maxi;
        end else if (r_sum < one_s) begin
            drive = DRIVE_W'(1);
        end else begin
            drive = r_sum[TEMP_FRAC_BITS +: DRIVE_W];
        end
    end

    // ------------------------------------------------------------------
    // Next state
    // ------------------------------------------------------------------
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: if (i_valid) n_state = S_MSQ;
            S_MSQ:  n_state = S_MDEN;
            S_MDEN: n_state = S_MNUM;
            S_MNUM: n_state = S_LOAD;
            S_LOAD: n_state = S_DIV;
            S_DIV:  if (div_done) n_state = S_SQRT;
            S_SQRT: if (sqrt_last) n_state = S_TEMP;
            S_TEMP: n_state = S_MI;
            S_MI:   n_state = S_INT;
            S_INT:  n_state = S_MP;
            S_MP:   n_state = S_MD;
            S_MD:   n_state = S_SUM;
            S_SUM:  n_state = S_FIN;
            S_FIN:  if (!r_out_valid || i_ready) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    // ------------------------------------------------------------------
    // Sequencer outputs: handshake, multiplier operands, unit commands
    // ------------------------------------------------------------------
    always_comb begin
        o_ready   = 1'b0;
        mul_a     = '0;
        mul_b     = '0;
        iter_ctrl = '0;
        case (r_state)
            // take no beat while reset is held
            S_IDLE: o_ready = i_rst_n;
            S_MSQ: begin
                // radicand 80000 * R
                mul_a = RAD_SCALE;
                mul_b = E_W'(r_coil_res);
            end
            S_MDEN: begin
                // divisor base * tcr; start the root on the radicand
                mul_a = OPA_W'(base_eff);
                mul_b = E_W'(tcr_eff);
                iter_ctrl.sqrt_load = 1'b1;
            end
            S_MNUM: begin
                mul_a = PPM_SCALE;
                mul_b = E_W'(mag);
            end
            S_LOAD: iter_ctrl.div_load  = 1'b1;
            S_DIV:  iter_ctrl.div_step  = 1'b1;
            S_SQRT: iter_ctrl.sqrt_step = 1'b1;
            S_MI: begin
                mul_a = OPA_W'(r_gain_i);
                mul_b = err;
            end
            S_MP: begin
                mul_a = OPA_W'(r_gain_p);
                mul_b = err;
            end
            S_MD: begin
                mul_a = OPA_W'(r_gain_d);
                mul_b = delta;
            end
            default: ;
        endcase
    end

    assign mul_prod = PW'($signed({1'b0, mul_a}) * mul_b);

    // ------------------------------------------------------------------
    // Control registers
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
            r_prev      <= '0;
            r_integ     <= '0;
            r_cnt       <= '0;
        end else begin
            r_state <= n_state;

            // hold the result until taken; reload from the final state
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end

            if (r_state == S_LOAD) begin
                r_cnt <= '0;
            end else if (r_state == S_DIV) begin
                r_cnt <= r_cnt + CNT_W'(1);
            end

            if (r_state == S_INT) begin
                r_integ <= integ_clamped;
            end

            if (out_load) begin
                r_prev <= r_temp;
            end
        end
    end

    // ------------------------------------------------------------------
    // Payload registers
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        r_prod <= mul_prod;

        if (r_state == S_IDLE && i_valid) begin
            r_coil_res <= i_coil_resistance;
        end
        if (r_state == S_MNUM) begin
            r_den <= r_prod[DEN_W-1:0];
            r_neg <= (r_coil_res < base_eff);
        end
        if (r_state == S_TEMP) begin
            r_temp <= t_sat;
            r_maxi <= root;
        end
        if (r_state == S_MD) begin
            // proportional term plus integral
            r_sum <= SW'(r_prod) + $signed(SW'(r_integ));
        end
        if (r_state == S_SUM) begin
            // subtract the derivative term
            r_sum <= r_sum - SW'(r_prod);
        end
        if (out_load) begin
            r_out_drive <= drive;
            r_out_temp  <= r_temp;
        end
    end

    assign o_valid            = r_out_valid;
    assign o_drive_voltage    = r_out_drive;
    assign o_coil_temperature = r_out_temp;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    // an accepted sample blocks the input for the whole computation
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && o_ready) |=> !o_ready)
        else $error("input ready right after an accepted beat");

    // a finished result always reaches the output register
    a_result_shown: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_load |=> o_valid)
        else $error("result loaded but o_valid low");

    // after its clamp the integral is within the output limit, or 1.0 when
    // the limit is zero
    a_integ_clamped: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_MP) |-> ((r_integ <= {r_maxi, {TEMP_FRAC_BITS{1'b0}}})
                               || (r_integ == ONE_FX)))
        else $error("integral above limit");

endmodule
`default_nettype wire

// ===== verif/coil_temperature_pid_regulator_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// coil_temperature_pid_regulator_tb
// Drives resistance samples into the regulator under several register
// settings and idle patterns. A local fixed-point model of the conversion and
// the PID step predicts each drive/temperature pair, which is compared with
// what the block returns in order.
// ----------------------------------------------------------------------------
module coil_temperature_pid_regulator_tb;
    import ctpr_pkg::*;

    localparam int FRAC_BITS      = 8;
    localparam int QUIET_LIMIT    = 4000;  // cycles with no beat on either side
    localparam int SETTLE_CYCLES  = 80;    // a little over one sample latency
    localparam int DIRECTED_ROWS  = 16;
    localparam int PHASE_ITEMS    = 76;
    localparam int PRESET_PHASES  = 6;
    localparam int RANDOM_PHASES  = 3;

    // One result as the block reports it
    typedef struct packed {
        logic [DRIVE_W-1:0]       drive;
        logic signed [TEMP_W-1:0] temp;
    } reading_t;

    // Directed row: a resistance and, where it is obvious, the result typed in
    typedef struct packed {
        logic [RES_W-1:0]         res;
        logic                     typed;
        logic [DRIVE_W-1:0]       drive;
        logic signed [TEMP_W-1:0] temp;
    } sample_row_t;

    // Rows run under the reset register values (setpoint 200, TCR 4300,
    // base 300 mOhm, gains 64/12/16) and start from cleared history.
    localparam sample_row_t STIM_TABLE [DIRECTED_ROWS] = '{
        // open coil: zero ceiling, positive output forced to zero
        '{15'd0,     1'b1, 16'd0,    TEMP_W'(-54414)},
        // resistance at base: exactly 20 C, output pinned at the ceiling
        '{15'd300,   1'b1, 16'd4898, TEMP_W'(5120)},
        // largest field value: temperature saturates high, drive floors at 1
        '{15'd32767, 1'b1, 16'd1,    TEMP_W'(262143)},
        '{15'd20000, 1'b0, 16'd0, TEMP_W'(0)},
        '{15'd1,     1'b0, 16'd0, TEMP_W'(0)},
        '{15'd299,   1'b0, 16'd0, TEMP_W'(0)},  // just below base: truncation
        '{15'd301,   1'b0, 16'd0, TEMP_W'(0)},
        '{15'd0,     1'b0, 16'd0, TEMP_W'(0)},  // zero ceiling after history
        '{15'd21845, 1'b0, 16'd0, TEMP_W'(0)},
        '{15'd10922, 1'b0, 16'd0, TEMP_W'(0)},
        '{15'd340,   1'b0, 16'd0, TEMP_W'(0)},
        '{15'd350,   1'b0, 16'd0, TEMP_W'(0)},
        '{15'd360,   1'b0, 16'd0, TEMP_W'(0)},
        '{15'd330,   1'b0, 16'd0, TEMP_W'(0)},
        '{15'd16384, 1'b0, 16'd0, TEMP_W'(0)},
        '{15'd8191,  1'b0, 16'd0, TEMP_W'(0)}
    };

    // Fixed register sets: setpoint, TCR, base, gain P, gain I, gain D
    localparam int PRESET [PRESET_PHASES][6] = '{
        '{200,   4300,  300,   64,   12,   16},   // reset values, written back
        '{0,     0,     0,     0,    0,    0},    // zero base and TCR act as 1
        '{511,   32767, 32767, 1023, 1023, 1023}, // every field at its top
        '{300,   20000, 20000, 1023, 1023, 1023}, // top of the working ranges
        '{20,    1,     1,     0,    0,    0},    // bottom of the working ranges
        '{250,   3900,  150,   200,  40,   100}
    };

    logic                     i_clk = 1'b0;
    logic                     i_rst_n = 1'b0;
    logic                     i_cfg_wr_en = 1'b0;
    logic [CFG_IDX_W-1:0]     i_cfg_index = CFG_SETPOINT;
    logic [CFG_DATA_W-1:0]    i_cfg_data = '0;
    logic                     i_valid = 1'b0;
    logic                     o_ready;
    logic [RES_W-1:0]         i_coil_resistance = '0;
    logic                     o_valid;
    logic                     i_ready = 1'b0;
    logic [DRIVE_W-1:0]       o_drive_voltage;
    logic signed [TEMP_W-1:0] o_coil_temperature;

    // Typed-in result that travels with the beat currently on the bus
    logic                     beat_typed = 1'b0;
    logic [DRIVE_W-1:0]       beat_drive = '0;
    logic signed [TEMP_W-1:0] beat_temp = '0;

    // Register shadow and regulator history of the local model
    logic [SP_W-1:0]          cfg_setpoint = RST_SETPOINT;
    logic [RES_W-1:0]         cfg_tcr = RST_TCR;
    logic [RES_W-1:0]         cfg_base = RST_BASE;
    logic [GAIN_W-1:0]        cfg_gain_p = RST_GAIN_P;
    logic [GAIN_W-1:0]        cfg_gain_i = RST_GAIN_I;
    logic [GAIN_W-1:0]        cfg_gain_d = RST_GAIN_D;
    longint                   last_temp = 0;
    longint                   integ_acc = 0;

    reading_t                 pending_readings [$];
    reading_t                 predicted_reading;
    reading_t                 seen_reading;

    int unsigned              samples_sent = 0;
    int unsigned              readings_seen = 0;
    int unsigned              quiet_cycles = 0;
    int unsigned              mismatch_count = 0;
    int unsigned              settings_loaded = 0;
    int                       send_idle_pct = 0;
    int                       stall_pct = 0;
    int                       ramp_deg = 0;

    coil_temperature_pid_regulator #(
        .TEMP_FRAC_BITS(FRAC_BITS)
    ) uut (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_cfg_wr_en        (i_cfg_wr_en),
        .i_cfg_index        (i_cfg_index),
        .i_cfg_data         (i_cfg_data),
        .i_valid            (i_valid),
        .o_ready            (o_ready),
        .i_coil_resistance  (i_coil_resistance),
        .o_valid            (o_valid),
        .i_ready            (i_ready),
        .o_drive_voltage    (o_drive_voltage),
        .o_coil_temperature (o_coil_temperature)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // ------------------------------------------------------------------------
    // Local model of one regulator step
    // ------------------------------------------------------------------------

    // Largest integer whose square does not exceed v (v below 2^32)
    function automatic longint root_floor(input longint v);
        longint acc;
        acc = 0;
        for (int b = 16; b >= 0; b--) begin
            if ((acc + (longint'(1) << b)) * (acc + (longint'(1) << b)) <= v)
                acc = acc + (longint'(1) << b);
        end
        return acc;
    endfunction

    // Convert the resistance, run the PID update and advance the history.
    function automatic void predict_regulator_step(input logic [RES_W-1:0] res,
                                                   output reading_t outcome);
        longint one, r, base, tcr, sp, gp, gi, gd;
        longint mag, quot, temp, err, delta, root, ceil_fx, acc, drive;
        one  = longint'(1) << FRAC_BITS;
        r    = res;
        base = (cfg_base == '0) ? 1 : cfg_base;
        tcr  = (cfg_tcr == '0) ? 1 : cfg_tcr;
        sp   = cfg_setpoint;
        gp   = cfg_gain_p;
        gi   = cfg_gain_i;
        gd   = cfg_gain_d;

        // Linear TCR model; the quotient truncates toward zero on either side
        mag  = (r < base) ? (base - r) : (r - base);
        quot = ((mag << FRAC_BITS) * 1000000) / (base * tcr);
        temp = (r < base) ? -quot : quot;
        temp = temp + REF_TEMP_C * one;
        if (temp > TEMP_MAX)
            temp = TEMP_MAX;
        else if (temp < TEMP_MIN)
            temp = TEMP_MIN;

        root    = root_floor(80000 * r);
        ceil_fx = root * one;
        err     = sp * one - temp;
        delta   = temp - last_temp;

        // Anti-windup: ceiling first, then the floor of 1.0
        acc = integ_acc + gi * err;
        if (acc > ceil_fx)
            acc = ceil_fx;
        else if (acc < one)
            acc = one;
        integ_acc = acc;

        // Derivative on measurement, then clamp and keep the integer part
        acc = gp * err + integ_acc - gd * delta;
        if (acc > ceil_fx)
            drive = root;
        else if (acc < one)
            drive = 1;
        else
            drive = acc >>> FRAC_BITS;

        last_temp     = temp;
        outcome.drive = DRIVE_W'(drive);
        outcome.temp  = TEMP_W'(temp);
    endfunction

    // ------------------------------------------------------------------------
    // Reporting
    // ------------------------------------------------------------------------

    task automatic flag_mismatch(input string what, input longint got,
                                 input longint want);
        $display("[%0t] MISMATCH %s: got %0d, want %0d (reading %0d)",
                 $realtime, what, got, want, readings_seen);
        mismatch_count++;
    endtask

    // ------------------------------------------------------------------------
    // Monitors: predict on every accepted sample, check every accepted result
    // ------------------------------------------------------------------------

    always @(posedge i_clk) begin
        if (i_rst_n && i_valid && o_ready) begin
            predict_regulator_step(i_coil_resistance, predicted_reading);
            // A typed-in row overrides the model for this beat only
            if (beat_typed) begin
                predicted_reading.drive = beat_drive;
                predicted_reading.temp  = beat_temp;
            end
            pending_readings.push_back(predicted_reading);
            samples_sent <= samples_sent + 1;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && i_ready) begin
            readings_seen <= readings_seen + 1;
            if (pending_readings.size() == 0) begin
                flag_mismatch("unexpected result beat, drive",
                              o_drive_voltage, 0);
            end else begin
                seen_reading = pending_readings.pop_front();
                if (o_drive_voltage !== seen_reading.drive)
                    flag_mismatch("drive_voltage", o_drive_voltage,
                                  seen_reading.drive);
                if (o_coil_temperature !== seen_reading.temp)
                    flag_mismatch("coil_temperature", o_coil_temperature,
                                  seen_reading.temp);
            end
        end
    end

    // Receiver: stall at the rate of the current phase
    always @(posedge i_clk) begin
        i_ready <= ($urandom_range(99) >= stall_pct);
    end

    // Watchdog: end the run if neither side moves for too long
    always @(posedge i_clk) begin
        if ((i_valid && o_ready) || (o_valid && i_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("[%0t] watchdog: no beat for %0d cycles", $realtime, quiet_cycles);
            $display("Test completed with failures");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Stimulus tasks
    // ------------------------------------------------------------------------

    // Present one sample and hold it until accepted. Valid is left high on
    // return so back-to-back beats never lower and raise it in one step.
    task automatic send_sample(input logic [RES_W-1:0] res, input logic typed,
                               input logic [DRIVE_W-1:0] drive,
                               input logic signed [TEMP_W-1:0] temp);
        while ($urandom_range(99) < send_idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid           <= 1'b1;
        i_coil_resistance <= res;
        beat_typed        <= typed;
        beat_drive        <= drive;
        beat_temp         <= temp;
        do @(posedge i_clk); while (!o_ready);
    endtask

    // Drop valid and hold until every predicted result has been returned
    task automatic drain_results();
        i_valid <= 1'b0;
        do @(posedge i_clk); while (samples_sent != readings_seen);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int value);
        i_cfg_wr_en <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= CFG_DATA_W'(value);
        case (idx)
            CFG_SETPOINT: cfg_setpoint = SP_W'(value);
            CFG_TCR:      cfg_tcr      = RES_W'(value);
            CFG_BASE:     cfg_base     = RES_W'(value);
            CFG_GAIN_P:   cfg_gain_p   = GAIN_W'(value);
            CFG_GAIN_I:   cfg_gain_i   = GAIN_W'(value);
            CFG_GAIN_D:   cfg_gain_d   = GAIN_W'(value);
            default: ;
        endcase
        @(posedge i_clk);
    endtask

    // Write all six registers; the block must be idle
    task automatic load_settings(input int sp, input int tcr, input int base,
                                 input int gp, input int gi, input int gd);
        write_reg(CFG_SETPOINT, sp);
        write_reg(CFG_TCR, tcr);
        write_reg(CFG_BASE, base);
        write_reg(CFG_GAIN_P, gp);
        write_reg(CFG_GAIN_I, gi);
        write_reg(CFG_GAIN_D, gd);
        i_cfg_wr_en <= 1'b0;
        settings_loaded++;
    endtask

    // Mostly a heating ramp around the configured coil, plus noise
    function automatic logic [RES_W-1:0] pick_resistance();
        longint base, tcr, r;
        base = (cfg_base == '0) ? 1 : cfg_base;
        tcr  = (cfg_tcr == '0) ? 1 : cfg_tcr;
        case ($urandom_range(19))
            0:       r = 0;
            1, 2:    r = $urandom_range(32767);
            3, 4:    r = $urandom_range(20000);
            default: begin
                ramp_deg = ramp_deg + $urandom_range(12) - 4;
                if (ramp_deg > 450)
                    ramp_deg = 450;
                else if (ramp_deg < -20)
                    ramp_deg = -20;
                r = base + (base * tcr * ramp_deg) / 1000000;
            end
        endcase
        if (r < 0)
            r = 0;
        else if (r > 32767)
            r = 32767;
        return RES_W'(r);
    endfunction

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------
    initial begin
        // Hold reset, then release once for the whole run
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed rows with no idling, against reset registers
        for (int k = 0; k < DIRECTED_ROWS; k++) begin
            send_sample(STIM_TABLE[k].res, STIM_TABLE[k].typed,
                        STIM_TABLE[k].drive, STIM_TABLE[k].temp);
        end
        drain_results();

        // Register phases: each loads preset or random registers while idle, then
        // runs a heating ramp under one of the four idle patterns
        for (int ph = 0; ph < PRESET_PHASES + RANDOM_PHASES; ph++) begin
            if (ph < PRESET_PHASES)
                load_settings(PRESET[ph][0], PRESET[ph][1], PRESET[ph][2],
                              PRESET[ph][3], PRESET[ph][4], PRESET[ph][5]);
            else
                load_settings($urandom_range(20, 300), $urandom_range(1, 20000),
                              $urandom_range(1, 20000), $urandom_range(1023),
                              $urandom_range(1023), $urandom_range(1023));

            case (ph % 4)
                0: begin send_idle_pct = 0;  stall_pct <= 0;  end
                1: begin send_idle_pct = 59; stall_pct <= 0;  end
                2: begin send_idle_pct = 0;  stall_pct <= 59; end
                default: begin send_idle_pct = 36; stall_pct <= 36; end
            endcase
            ramp_deg = $urandom_range(20) - 20;

            for (int n = 0; n < PHASE_ITEMS; n++) begin
                // In phase 2 only, mid-phase, hold the sender until the pipe is empty
                if (ph == 2 && n == PHASE_ITEMS / 2)
                    drain_results();
                send_sample(pick_resistance(), 1'b0, '0, '0);
            end
            drain_results();
        end

        // Everything returned; let the block settle before closing
        stall_pct <= 0;
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (pending_readings.size() != 0)
            flag_mismatch("results still outstanding", 0, pending_readings.size());

        $display("Ran %0d samples under %0d register settings with four idle patterns;",
                 samples_sent, settings_loaded + 1);
        $display("checked %0d results field by field, %0d mismatches.",
                 readings_seen, mismatch_count);
        if (mismatch_count == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule

// ===== files.f =====
sv/ctpr_pkg.sv
sv/ctpr_iter_unit.sv
sv/coil_temperature_pid_regulator.sv
verif/coil_temperature_pid_regulator_tb.sv
